/* src/indexed_list_engine_defines.svh */
// Assertion helpers for the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ILE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ILE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ile_pkg.sv */
`timescale 1ns / 1ps

package ile_pkg;

   localparam int ILE_CAPACITY      = 256;
   localparam int ILE_ELEMENT_BITS  = 32;

   // fixed port widths
   localparam int OPCODE_BITS       = 3;
   localparam int POSITION_BITS     = 9;
   localparam int ELEMENT_PORT_BITS = 32;
   localparam int STATUS_BITS       = 2;
   localparam int FOUND_POS_BITS    = 8;
   localparam int COUNT_PORT_BITS   = 9;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_GET    = 3'd2,
      OP_SET    = 3'd3,
      OP_REMOVE = 3'd4,
      OP_SEARCH = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_SHIFT,
      S_INS_PUT,
      S_GET_WAIT,
      S_REM_READ,
      S_REM_SHIFT,
      S_SEARCH,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RA_ZERO,
      RA_POS,
      RA_POS_UP,
      RA_COUNT_DOWN,
      RA_IDX_UP,
      RA_IDX_DOWN
   } ra_sel_type;

   typedef enum logic [1:0] {
      WA_COUNT,
      WA_POS,
      WA_IDX_UP,
      WA_IDX_DOWN
   } wa_sel_type;

   typedef enum logic {
      WD_ELEMENT,
      WD_READ
   } wd_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef struct packed {
      logic       req_ready;
      logic       load_req;
      logic       set_status;
      status_type status;
      logic       cap_read;
      logic       cap_found;
      logic       mem_wr;
      wa_sel_type wa_sel;
      wd_sel_type wd_sel;
      logic       mem_rd;
      ra_sel_type ra_sel;
      cnt_op_type cnt_op;
      logic       out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type opcode;
      logic   pos_gt_count;
      logic   pos_ge_count;
      logic   pos_next_lt_count;
      logic   idx_next_lt_count;
      logic   idx_is_pos;
      logic   full;
      logic   count_zero;
      logic   match;
      logic   out_free;
   } dp_status_type;

endpackage

/* src/ile_ram.sv */
`timescale 1ns / 1ps

module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ile_dpath.sv */
`timescale 1ns / 1ps

module ile_dpath import ile_pkg::*; #(
   parameter int CAPACITY     = ILE_CAPACITY,
   parameter int ELEMENT_BITS = ILE_ELEMENT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [OPCODE_BITS-1:0]       req_opcode,
   input  logic [POSITION_BITS-1:0]     req_position,
   input  logic [ELEMENT_PORT_BITS-1:0] req_element,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic [ELEMENT_PORT_BITS-1:0] rsp_read_element,
   output logic                         rsp_found,
   output logic [FOUND_POS_BITS-1:0]    rsp_found_position,
   output logic [COUNT_PORT_BITS-1:0]   rsp_entry_count,
   output logic                         rsp_list_empty,
   input  ctrl_cmd_type                 cmd,
   output dp_status_type                st
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > POSITION_BITS) ? CW : POSITION_BITS) + 1;

   // request held for the whole transaction
   logic [OPCODE_BITS-1:0]   opcode_ff;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [ELEMENT_BITS-1:0]  elem_ff;

   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           idx_ff;
   status_type              status_ff;
   logic [ELEMENT_BITS-1:0] rd_ff;
   logic                    found_ff;
   logic [AW-1:0]           fpos_ff;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   status_type                   out_status_ff;
   logic [ELEMENT_PORT_BITS-1:0] out_rd_ff;
   logic                         out_found_ff;
   logic [FOUND_POS_BITS-1:0]    out_fpos_ff;
   logic [COUNT_PORT_BITS-1:0]   out_count_ff;
   logic                         out_empty_ff;

   logic [AW-1:0]           ra, wa;
   logic [ELEMENT_BITS-1:0] wd, mem_rdata;
   logic [XW-1:0]           pos_x, cnt_x, idx_x;

   always_comb begin
      unique case (cmd.ra_sel)
         RA_ZERO:       ra = '0;
         RA_POS:        ra = AW'(pos_ff);
         RA_POS_UP:     ra = AW'(pos_ff) + AW'(1);
         RA_COUNT_DOWN: ra = AW'(count_ff - CW'(1));
         RA_IDX_UP:     ra = idx_ff + AW'(1);
         RA_IDX_DOWN:   ra = idx_ff - AW'(1);
         default:       ra = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wa_sel)
         WA_COUNT:    wa = AW'(count_ff);
         WA_POS:      wa = AW'(pos_ff);
         WA_IDX_UP:   wa = idx_ff + AW'(1);
         WA_IDX_DOWN: wa = idx_ff - AW'(1);
         default:     wa = '0;
      endcase
   end

   assign wd = (cmd.wd_sel == WD_READ) ? mem_rdata : elem_ff;

   ile_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_wr),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_en   (cmd.mem_rd),
      .rd_addr (ra),
      .rd_data (mem_rdata)
   );

   always_comb begin
      unique case (cmd.cnt_op)
         CNT_HOLD:  count_in = count_ff;
         CNT_INC:   count_in = count_ff + CW'(1);
         CNT_DEC:   count_in = count_ff - CW'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         opcode_ff <= req_opcode;
         pos_ff    <= req_position;
         elem_ff   <= ELEMENT_BITS'(req_element);
         status_ff <= ST_OK;
         rd_ff     <= '0;
         found_ff  <= 1'b0;
         fpos_ff   <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cmd.cap_read) begin
            rd_ff <= mem_rdata;
         end
         if (cmd.cap_found) begin
            found_ff <= 1'b1;
            fpos_ff  <= idx_ff;
         end
      end
      // index follows the last read address
      if (cmd.mem_rd) begin
         idx_ff <= ra;
      end
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_rd_ff     <= ELEMENT_PORT_BITS'(rd_ff);
         out_found_ff  <= found_ff;
         out_fpos_ff   <= FOUND_POS_BITS'(fpos_ff);
         out_count_ff  <= COUNT_PORT_BITS'(count_ff);
         out_empty_ff  <= (count_ff == '0);
      end
   end

   assign pos_x = XW'(pos_ff);
   assign cnt_x = XW'(count_ff);
   assign idx_x = XW'(idx_ff);

   assign st.opcode            = op_type'(opcode_ff);
   assign st.pos_gt_count      = (pos_x > cnt_x);
   assign st.pos_ge_count      = (pos_x >= cnt_x);
   assign st.pos_next_lt_count = ((pos_x + XW'(1)) < cnt_x);
   assign st.idx_next_lt_count = ((idx_x + XW'(1)) < cnt_x);
   assign st.idx_is_pos        = (idx_x == pos_x);
   assign st.full              = (cnt_x == XW'(CAPACITY));
   assign st.count_zero        = (count_ff == '0);
   assign st.match             = (mem_rdata == elem_ff);
   assign st.out_free          = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_read_element   = out_rd_ff;
   assign rsp_found          = out_found_ff;
   assign rsp_found_position = out_fpos_ff;
   assign rsp_entry_count    = out_count_ff;
   assign rsp_list_empty     = out_empty_ff;

endmodule

/* src/ile_ctrl.sv */
`timescale 1ns / 1ps

module ile_ctrl import ile_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type st,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            unique case (st.opcode)
               OP_APPEND: begin
                  if (st.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.mem_wr = 1'b1;
                     cmd.wa_sel = WA_COUNT;
                     cmd.wd_sel = WD_ELEMENT;
                     cmd.cnt_op = CNT_INC;
                  end
               end
               OP_INSERT: begin
                  priority if (st.pos_gt_count) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_RANGE;
                  end else if (st.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else if (st.pos_ge_count) begin
                     // insert at the tail: nothing to move
                     cmd.mem_wr = 1'b1;
                     cmd.wa_sel = WA_POS;
                     cmd.wd_sel = WD_ELEMENT;
                     cmd.cnt_op = CNT_INC;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     cmd.ra_sel = RA_COUNT_DOWN;
                     state_in   = S_INS_SHIFT;
                  end
               end
               OP_GET: begin
                  if (st.pos_ge_count) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_RANGE;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     cmd.ra_sel = RA_POS;
                     state_in   = S_GET_WAIT;
                  end
               end
               OP_SET: begin
                  if (st.pos_ge_count) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_RANGE;
                  end else begin
                     cmd.mem_wr = 1'b1;
                     cmd.wa_sel = WA_POS;
                     cmd.wd_sel = WD_ELEMENT;
                  end
               end
               OP_REMOVE: begin
                  if (st.pos_ge_count) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_RANGE;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     cmd.ra_sel = RA_POS;
                     state_in   = S_REM_READ;
                  end
               end
               OP_SEARCH: begin
                  if (!st.count_zero) begin
                     cmd.mem_rd = 1'b1;
                     cmd.ra_sel = RA_ZERO;
                     state_in   = S_SEARCH;
                  end
               end
               OP_CLEAR: begin
                  cmd.cnt_op = CNT_CLEAR;
               end
               default: begin
                  // unused opcode: report the count only
               end
            endcase
         end
         S_INS_SHIFT: begin
            cmd.mem_wr = 1'b1;
            cmd.wa_sel = WA_IDX_UP;
            cmd.wd_sel = WD_READ;
            if (st.idx_is_pos) begin
               state_in = S_INS_PUT;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.ra_sel = RA_IDX_DOWN;
            end
         end
         S_INS_PUT: begin
            cmd.mem_wr = 1'b1;
            cmd.wa_sel = WA_POS;
            cmd.wd_sel = WD_ELEMENT;
            cmd.cnt_op = CNT_INC;
            state_in   = S_FINISH;
         end
         S_GET_WAIT: begin
            cmd.cap_read = 1'b1;
            state_in     = S_FINISH;
         end
         S_REM_READ: begin
            cmd.cap_read = 1'b1;
            if (st.pos_next_lt_count) begin
               cmd.mem_rd = 1'b1;
               cmd.ra_sel = RA_POS_UP;
               state_in   = S_REM_SHIFT;
            end else begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_FINISH;
            end
         end
         S_REM_SHIFT: begin
            cmd.mem_wr = 1'b1;
            cmd.wa_sel = WA_IDX_DOWN;
            cmd.wd_sel = WD_READ;
            if (st.idx_next_lt_count) begin
               cmd.mem_rd = 1'b1;
               cmd.ra_sel = RA_IDX_UP;
            end else begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_FINISH;
            end
         end
         S_SEARCH: begin
            priority if (st.match) begin
               cmd.cap_found = 1'b1;
               state_in      = S_FINISH;
            end else if (st.idx_next_lt_count) begin
               cmd.mem_rd = 1'b1;
               cmd.ra_sel = RA_IDX_UP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* src/indexed_list_engine.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  opcode, position, element
// rsp_      out        rsp_valid/rsp_ready  status, read_element, found,
//                                           found_position, entry_count, list_empty
//
// One transaction in flight. Insert and remove shift the entries from position to the
// end of the list, and search compares entries from index 0 until a match or the end,
// one entry moved or compared a cycle, set by the single read and single write port of
// the entry RAM.
// Reset clears the entry count and the output valid synchronously; the RAM is not cleared.
// A new request is taken while a finished response still waits on rsp_ready; the
// engine only holds in its last step if that response has not yet gone.

`include "indexed_list_engine_defines.svh"

module indexed_list_engine import ile_pkg::*; #(
   parameter int CAPACITY     = ILE_CAPACITY,
   parameter int ELEMENT_BITS = ILE_ELEMENT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [OPCODE_BITS-1:0]       req_opcode,
   input  logic [POSITION_BITS-1:0]     req_position,
   input  logic [ELEMENT_PORT_BITS-1:0] req_element,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic [ELEMENT_PORT_BITS-1:0] rsp_read_element,
   output logic                         rsp_found,
   output logic [FOUND_POS_BITS-1:0]    rsp_found_position,
   output logic [COUNT_PORT_BITS-1:0]   rsp_entry_count,
   output logic                         rsp_list_empty
);

   ctrl_cmd_type  cmd;
   dp_status_type st;

   // sequencer: walks each opcode through its read, shift and compare steps
   ile_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .st        (st),
      .cmd       (cmd)
   );

   // datapath: entry RAM, count, index, result and output registers
   ile_dpath #(
      .CAPACITY     (CAPACITY),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_element        (req_element),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_read_element   (rsp_read_element),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_list_empty     (rsp_list_empty),
      .cmd                (cmd),
      .st                 (st)
   );

   assign req_ready = cmd.req_ready;

   // one transaction at a time: busy straight after taking a request
   `ILE_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
                   "request taken while a transaction was in flight")
   // a failed operation returns no element and no match
   `ILE_ASSERT_IMP(a_error_clean, rsp_valid && (rsp_status != ST_OK),
                   (rsp_read_element == '0) && !rsp_found,
                   "error response carries data")
   // a match only comes from a successful search, which reads nothing back
   `ILE_ASSERT_IMP(a_found_clean, rsp_valid && rsp_found,
                   (rsp_status == ST_OK) && (rsp_read_element == '0),
                   "match reported with error or read data")

endmodule
